### rtl/core/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg: shared types and helpers for the three-component vector ALU
// Operation and error codes, sideband words and the word saturation helper.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned DivW         = WordW + 1;
  localparam int unsigned SumW         = 2 * WordW;
  localparam int unsigned RootW        = WordW;
  localparam int unsigned MagW         = WordW - 1;
  localparam int unsigned WideW        = SumW + 1;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    OP_VADD  = 4'd0,
    OP_VSUB  = 4'd1,
    OP_VMUL  = 4'd2,
    OP_VDIV  = 4'd3,
    OP_SADD  = 4'd4,
    OP_SSUB  = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SDIV  = 4'd7,
    OP_NEG   = 4'd8,
    OP_LEN   = 4'd9,
    OP_NORM  = 4'd10,
    OP_CROSS = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_DIV_ZERO  = 2'd1,
    ERR_NORM_ZERO = 2'd2
  } err_e;

  typedef struct packed {
    op_e                       op;
    logic [2:0][WordW-1:0]     a;
    logic [2:0][DivW-1:0]      dvs;
    logic [2:0][WordW-1:0]     r;
    err_e                      err;
  } sq_side_t;

  typedef struct packed {
    op_e                       op;
    logic [2:0][WordW-1:0]     r;
    logic [MagW-1:0]           mag;
    logic [2:0]                neg;
    err_e                      err;
  } div_side_t;

  function automatic logic [WordW-1:0] sat_word(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(signed'({1'b0, {(WordW-1){1'b1}}}));
    lo = -hi - WideW'(signed'(1));
    if (v > hi) begin
      return {1'b0, {(WordW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(WordW-1){1'b0}}};
    end
    return v[WordW-1:0];
  endfunction

endpackage

### rtl/core/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front: product and combine stages
// Stage one forms six products, stage two adds, shifts and saturates them and
// forms the sum of squares and divisor selection for the later stages.
// ----------------------------------------------------------------------------
module v3a_front #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [3:0]                    req_type_i,
  input  logic [v3a_pkg::WordW-1:0]     a_i [3],
  input  logic [v3a_pkg::WordW-1:0]     b_i [3],
  input  logic [v3a_pkg::WordW-1:0]     s_i,
  output logic                          valid_o,
  output logic [v3a_pkg::SumW-1:0]      sum_o,
  output v3a_pkg::sq_side_t             side_o
);
  import v3a_pkg::*;

  op_e                      op_d;
  logic signed [WordW-1:0]  ma [3];
  logic signed [WordW-1:0]  mb [3];
  logic signed [SumW-1:0]   pm_d [3];
  logic signed [SumW-1:0]   pc_d [3];

  logic                     s1_valid_q;
  op_e                      s1_op_q;
  logic [WordW-1:0]         s1_a_q [3];
  logic [WordW-1:0]         s1_b_q [3];
  logic [WordW-1:0]         s1_s_q;
  logic signed [SumW-1:0]   s1_pm_q [3];
  logic signed [SumW-1:0]   s1_pc_q [3];

  sq_side_t                 side_d;
  logic [SumW-1:0]          sum_d;
  logic                     s2_valid_q;
  logic [SumW-1:0]          s2_sum_q;
  sq_side_t                 s2_side_q;

  assign op_d = op_e'(req_type_i);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = signed'(a_i[i]);
      case (op_d)
        OP_SMUL:         mb[i] = signed'(s_i);
        OP_LEN, OP_NORM: mb[i] = signed'(a_i[i]);
        default:         mb[i] = signed'(b_i[i]);
      endcase
    end
    if (op_d == OP_CROSS) begin
      ma[0] = signed'(a_i[1]); mb[0] = signed'(b_i[2]);
      ma[1] = signed'(a_i[2]); mb[1] = signed'(b_i[0]);
      ma[2] = signed'(a_i[0]); mb[2] = signed'(b_i[1]);
    end
    for (int i = 0; i < 3; i++) begin
      pm_d[i] = ma[i] * mb[i];
    end
    pc_d[0] = signed'(a_i[2]) * signed'(b_i[1]);
    pc_d[1] = signed'(a_i[0]) * signed'(b_i[2]);
    pc_d[2] = signed'(a_i[1]) * signed'(b_i[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_op_q <= op_d;
      s1_s_q  <= s_i;
      for (int i = 0; i < 3; i++) begin
        s1_a_q[i]  <= a_i[i];
        s1_b_q[i]  <= b_i[i];
        s1_pm_q[i] <= pm_d[i];
        s1_pc_q[i] <= pc_d[i];
      end
    end
  end

  always_comb begin
    logic signed [WideW-1:0] wa;
    logic signed [WideW-1:0] wb;
    logic signed [WideW-1:0] ws;
    logic signed [WideW-1:0] wp;
    logic signed [WideW-1:0] wc;
    side_d.op  = s1_op_q;
    side_d.err = ERR_NONE;
    ws = WideW'(signed'(s1_s_q));
    sum_d = SumW'(unsigned'(s1_pm_q[0])) + SumW'(unsigned'(s1_pm_q[1]))
          + SumW'(unsigned'(s1_pm_q[2]));
    for (int i = 0; i < 3; i++) begin
      wa = WideW'(signed'(s1_a_q[i]));
      wb = WideW'(signed'(s1_b_q[i]));
      wp = WideW'(s1_pm_q[i]);
      wc = WideW'(s1_pc_q[i]);
      side_d.a[i] = s1_a_q[i];
      if (s1_op_q == OP_SDIV) begin
        side_d.dvs[i] = DivW'(signed'(s1_s_q));
      end else begin
        side_d.dvs[i] = DivW'(signed'(s1_b_q[i]));
      end
      case (s1_op_q)
        OP_VADD:          side_d.r[i] = sat_word(wa + wb);
        OP_VSUB:          side_d.r[i] = sat_word(wa - wb);
        OP_SADD:          side_d.r[i] = sat_word(wa + ws);
        OP_SSUB:          side_d.r[i] = sat_word(wa - ws);
        OP_NEG:           side_d.r[i] = sat_word(-wa);
        OP_VMUL, OP_SMUL: side_d.r[i] = sat_word(wp >>> FRAC_BITS);
        OP_CROSS:         side_d.r[i] = sat_word((wp - wc) >>> FRAC_BITS);
        default:          side_d.r[i] = '0;
      endcase
    end
    if (s1_op_q == OP_VDIV &&
        (s1_b_q[0] == '0 || s1_b_q[1] == '0 || s1_b_q[2] == '0)) begin
      side_d.err = ERR_DIV_ZERO;
    end
    if (s1_op_q == OP_SDIV && s1_s_q == '0) begin
      side_d.err = ERR_DIV_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_sum_q  <= sum_d;
      s2_side_q <= side_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign sum_o   = s2_sum_q;
  assign side_o  = s2_side_q;

endmodule

### rtl/core/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt: pipelined floor square root
// One root bit per register stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module v3a_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [v3a_pkg::SumW-1:0]      sum_i,
  input  v3a_pkg::sq_side_t             side_i,
  output logic                          valid_o,
  output logic [v3a_pkg::RootW-1:0]     root_o,
  output v3a_pkg::sq_side_t             side_o
);
  import v3a_pkg::*;

  localparam int unsigned Stages = RootW;
  localparam int unsigned RemW   = RootW + 2;

  logic                 valid_q [Stages];
  logic [RemW-1:0]      rem_q   [Stages];
  logic [RootW-1:0]     root_q  [Stages];
  logic [SumW-1:0]      num_q   [Stages];
  sq_side_t             side_q  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic             valid_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SumW-1:0]  num_in;
    sq_side_t         side_in;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  part;
    logic             ge;

    if (k == 0) begin : g_src
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign num_in   = sum_i;
      assign side_in  = side_i;
    end else begin : g_src
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign num_in   = num_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign part  = {rem_in[RemW-3:0], num_in[SumW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = part >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= ge ? part - trial : part;
        root_q[k] <= {root_in[RootW-2:0], ge};
        num_q[k]  <= {num_in[SumW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign root_o  = root_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

### rtl/core/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div: pipelined three-lane unsigned divider
// Restoring division, one quotient bit per register stage in every lane.
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter  int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
  localparam int unsigned QuotW     = v3a_pkg::WordW + FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [QuotW-1:0]              dividend_i [3],
  input  logic [v3a_pkg::DivW-1:0]      divisor_i  [3],
  input  v3a_pkg::div_side_t            side_i,
  output logic                          valid_o,
  output logic [QuotW-1:0]              quot_o [3],
  output v3a_pkg::div_side_t            side_o
);
  import v3a_pkg::*;

  localparam int unsigned Stages = QuotW;

  logic                 valid_q [Stages];
  logic [DivW-1:0]      rem_q   [Stages][3];
  logic [QuotW-1:0]     nq_q    [Stages][3];
  logic [DivW-1:0]      dv_q    [Stages][3];
  div_side_t            side_q  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic             valid_in;
    div_side_t        side_in;

    if (k == 0) begin : g_src
      assign valid_in = valid_i;
      assign side_in  = side_i;
    end else begin : g_src
      assign valid_in = valid_q[k-1];
      assign side_in  = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DivW-1:0]  rem_in;
      logic [QuotW-1:0] nq_in;
      logic [DivW-1:0]  dv_in;
      logic [DivW:0]    part;
      logic [DivW:0]    diff;
      logic             ge;

      if (k == 0) begin : g_src
        assign rem_in = '0;
        assign nq_in  = dividend_i[l];
        assign dv_in  = divisor_i[l];
      end else begin : g_src
        assign rem_in = rem_q[k-1][l];
        assign nq_in  = nq_q[k-1][l];
        assign dv_in  = dv_q[k-1][l];
      end

      assign part = {rem_in, nq_in[QuotW-1]};
      assign diff = part - {1'b0, dv_in};
      assign ge   = part >= {1'b0, dv_in};

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k][l] <= ge ? diff[DivW-1:0] : part[DivW-1:0];
          nq_q[k][l]  <= {nq_in[QuotW-2:0], ge};
          dv_q[k][l]  <= dv_in;
        end
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign side_o  = side_q[Stages-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quot_o[l] = nq_q[Stages-1][l];
  end

endmodule

### rtl/core/vec3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu: three-component fixed point vector ALU
//
//   channel  valid        stall        word
//   request  in_valid_i   in_stall_o   req_type_i, a_*_i, b_*_i, scalar_operand_i
//   result   out_valid_o  out_stall_i  r_*_o, magnitude_o, error_code_o
//
// One word enters per cycle while in_stall_o is low. The pipeline holds two
// product stages, 32 root stages, one divisor setup stage, 32 + FRAC_BITS
// divider stages (FRAC_BITS is 16 at Q16.16) and the output register. Reset
// clears all valid bits. A stall on a waiting result freezes every stage.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3:0]                    req_type_i,
  input  logic [v3a_pkg::WordW-1:0]     a_x_i,
  input  logic [v3a_pkg::WordW-1:0]     a_y_i,
  input  logic [v3a_pkg::WordW-1:0]     a_z_i,
  input  logic [v3a_pkg::WordW-1:0]     b_x_i,
  input  logic [v3a_pkg::WordW-1:0]     b_y_i,
  input  logic [v3a_pkg::WordW-1:0]     b_z_i,
  input  logic [v3a_pkg::WordW-1:0]     scalar_operand_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [v3a_pkg::WordW-1:0]     r_x_o,
  output logic [v3a_pkg::WordW-1:0]     r_y_o,
  output logic [v3a_pkg::WordW-1:0]     r_z_o,
  output logic [v3a_pkg::MagW-1:0]      magnitude_o,
  output logic [1:0]                    error_code_o
);
  import v3a_pkg::*;

  localparam int unsigned QuotW = WordW + FRAC_BITS;

  logic              adv;
  logic [WordW-1:0]  a_in [3];
  logic [WordW-1:0]  b_in [3];

  logic              fr_valid;
  logic [SumW-1:0]   fr_sum;
  sq_side_t          fr_side;

  logic              sq_valid;
  logic [RootW-1:0]  sq_root;
  sq_side_t          sq_side;

  logic [QuotW-1:0]  dvd_d [3];
  logic [DivW-1:0]   dvs_d [3];
  div_side_t         su_side_d;
  logic              su_valid_q;
  logic [QuotW-1:0]  su_dvd_q [3];
  logic [DivW-1:0]   su_dvs_q [3];
  div_side_t         su_side_q;

  logic              dv_valid;
  logic [QuotW-1:0]  dv_quot [3];
  div_side_t         dv_side;

  logic [WordW-1:0]  res_d [3];
  logic              out_valid_q;
  logic [WordW-1:0]  res_q [3];
  logic [MagW-1:0]   mag_q;
  err_e              err_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign a_in[0] = a_x_i;
  assign a_in[1] = a_y_i;
  assign a_in[2] = a_z_i;
  assign b_in[0] = b_x_i;
  assign b_in[1] = b_y_i;
  assign b_in[2] = b_z_i;

  v3a_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .req_type_i (req_type_i),
    .a_i        (a_in),
    .b_i        (b_in),
    .s_i        (scalar_operand_i),
    .valid_o    (fr_valid),
    .sum_o      (fr_sum),
    .side_o     (fr_side)
  );

  v3a_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_valid),
    .sum_i   (fr_sum),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  always_comb begin
    logic [WordW-1:0] a_abs;
    logic [DivW-1:0]  d;
    su_side_d.op  = sq_side.op;
    su_side_d.r   = sq_side.r;
    su_side_d.err = sq_side.err;
    su_side_d.mag = '0;
    if (sq_side.op == OP_NORM && sq_root == '0) begin
      su_side_d.err = ERR_NORM_ZERO;
    end
    if (sq_side.op == OP_LEN || sq_side.op == OP_NORM) begin
      su_side_d.mag = (sq_root[RootW-1]) ? {MagW{1'b1}} : sq_root[MagW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      a_abs    = sq_side.a[i][WordW-1] ? WordW'(0) - sq_side.a[i] : sq_side.a[i];
      dvd_d[i] = {a_abs, {FRAC_BITS{1'b0}}};
      if (sq_side.op == OP_NORM) begin
        d = {1'b0, sq_root};
        su_side_d.neg[i] = sq_side.a[i][WordW-1];
      end else begin
        d = sq_side.dvs[i];
        su_side_d.neg[i] = sq_side.a[i][WordW-1] ^ d[DivW-1];
      end
      dvs_d[i] = d[DivW-1] ? DivW'(0) - d : d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_valid_q <= 1'b0;
    end else if (adv) begin
      su_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      su_side_q <= su_side_d;
      for (int i = 0; i < 3; i++) begin
        su_dvd_q[i] <= dvd_d[i];
        su_dvs_q[i] <= dvs_d[i];
      end
    end
  end

  v3a_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (su_valid_q),
    .dividend_i (su_dvd_q),
    .divisor_i  (su_dvs_q),
    .side_i     (su_side_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  always_comb begin
    logic signed [WideW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = WideW'(signed'({1'b0, dv_quot[i]}));
      if (dv_side.neg[i]) begin
        q = -q;
      end
      if (dv_side.err != ERR_NONE) begin
        res_d[i] = '0;
      end else begin
        case (dv_side.op)
          OP_VDIV, OP_SDIV, OP_NORM: res_d[i] = sat_word(q);
          default:                   res_d[i] = dv_side.r[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      mag_q <= (dv_side.err != ERR_NONE) ? '0 : dv_side.mag;
      err_q <= dv_side.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign r_x_o        = res_q[0];
  assign r_y_o        = res_q[1];
  assign r_z_o        = res_q[2];
  assign magnitude_o  = mag_q;
  assign error_code_o = err_q;

  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no waiting result");

  a_error_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |->
      r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && magnitude_o == '0)
    else $error("error result carries nonzero fields");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r_x_o) && $stable(error_code_o))
    else $error("stalled result changed");

endmodule
